FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file of the stack set engine.
// Each macro expands to one labeled concurrent assertion clocked on the
// rising edge and held off while the synchronous reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/bss_pkg.sv
// Package for the bounded stack set engine: command, status and state codes,
// port field widths and the structs between controller and datapath.
// No dependencies.
`default_nettype none

package bss_pkg;

   // Fixed field widths of the streaming ports.
   localparam int PUSH_VALUE_W  = 32;
   localparam int STACK_INDEX_W = 6;
   localparam int REQ_DATA_W    = 40;
   localparam int RSP_DATA_W    = 32;
   localparam int CODE_W        = 2;
   localparam int CAP_W         = 5;
   localparam int WIDE_W        = 64;
   localparam int CAP_RESET     = 16;

   // Request kinds carried on req_tuser.
   typedef enum logic [CODE_W-1:0] {
      CMD_PUSH   = 2'd0,
      CMD_POP    = 2'd1,
      CMD_POP_AT = 2'd2
   } cmd_type;

   // Result status carried on rsp_tuser.
   typedef enum logic [CODE_W-1:0] {
      ST_DONE = 2'd0,
      ST_NONE = 2'd1,
      ST_FULL = 2'd2
   } stat_type;

   // Controller states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_FETCH,
      S_EXAMINE,
      S_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic     accept;
      logic     fetch;
      logic     step_up;
      logic     step_down;
      logic     write_push;
      logic     open_new;
      logic     take;
      logic     set_result;
      stat_type result_code;
      logic     load_rsp;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      cmd_type cmd;
      logic    index_bad;
      logic    has_room;
      logic    is_empty;
      logic    at_last;
      logic    at_zero;
      logic    can_open;
      logic    rsp_busy;
   } dp_flags_type;

endpackage

`default_nettype wire

FILE: hdl/bounded_stack_set_engine.sv
// An unknown command or a bad stack index goes from decode straight to the
// finish state; a push or a pop fetches a fill count and examines it, and the
// scan adds one fill count memory read and one check per stack it passes.
// One transaction is in work at a time; the next is taken once the result is
// in the output register. Synchronous reset clears counts and the scan state.
`default_nettype none

module bounded_stack_set_engine import bss_pkg::*; #(
   parameter int STACK_COUNT  = 64,
   parameter int MAX_CAPACITY = 16,
   parameter int VALUE_WIDTH  = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // Capacity register write.
   input  wire logic                    csr_wr_en,
   input  wire logic [CAP_W-1:0]        csr_wr_data,
   // Requests.
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [REQ_DATA_W-1:0]   req_tdata,  // push_value[31:0], stack_index[37:32]
   input  wire logic [CODE_W-1:0]       req_tuser,  // command[1:0]
   // Results.
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic      [RSP_DATA_W-1:0]   rsp_tdata,  // pop_value[31:0]
   output logic      [CODE_W-1:0]       rsp_tuser   // status[1:0]
);

   ctl_cmd_type  cmd;
   dp_flags_type flags;

   bss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .flags      (flags),
      .cmd        (cmd)
   );

   bss_dp #(
      .STACK_COUNT  (STACK_COUNT),
      .MAX_CAPACITY (MAX_CAPACITY),
      .VALUE_WIDTH  (VALUE_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .cmd         (cmd),
      .flags       (flags)
   );

endmodule

`default_nettype wire

FILE: hdl/bss_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the stack word store and the per-stack fill counts. No dependencies.
`default_nettype none

module bss_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 16,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; read data holds between reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/bss_ctrl.sv
// Controller state machine of the stack set engine: sequences the stack
// scans, pushes and pops. Depends on bss_pkg.
`default_nettype none

module bss_ctrl import bss_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire dp_flags_type flags,
   output ctl_cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.result_code = ST_DONE;
      req_tready      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (flags.cmd)
               CMD_PUSH, CMD_POP: begin
                  cmd.fetch = 1'b1;
                  state_in  = S_EXAMINE;
               end
               CMD_POP_AT: begin
                  if (flags.index_bad) begin
                     cmd.set_result  = 1'b1;
                     cmd.result_code = ST_NONE;
                     state_in        = S_FINISH;
                  end else begin
                     cmd.fetch = 1'b1;
                     state_in  = S_EXAMINE;
                  end
               end
               default: begin
                  // An unknown command changes nothing and reports done.
                  cmd.set_result = 1'b1;
                  state_in       = S_FINISH;
               end
            endcase
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_EXAMINE;
         end
         S_EXAMINE: begin
            unique case (flags.cmd)
               CMD_PUSH: begin
                  priority if (flags.has_room) begin
                     cmd.write_push = 1'b1;
                     cmd.set_result = 1'b1;
                     state_in       = S_FINISH;
                  end else if (!flags.at_last) begin
                     cmd.step_up = 1'b1;
                     state_in    = S_FETCH;
                  end else if (flags.can_open) begin
                     cmd.write_push = 1'b1;
                     cmd.open_new   = 1'b1;
                     cmd.set_result = 1'b1;
                     state_in       = S_FINISH;
                  end else begin
                     cmd.set_result  = 1'b1;
                     cmd.result_code = ST_FULL;
                     state_in        = S_FINISH;
                  end
               end
               CMD_POP: begin
                  // Drop trailing empty stacks before taking a value.
                  priority if (flags.is_empty && !flags.at_zero) begin
                     cmd.step_down = 1'b1;
                     state_in      = S_FETCH;
                  end else if (flags.is_empty) begin
                     cmd.set_result  = 1'b1;
                     cmd.result_code = ST_NONE;
                     state_in        = S_FINISH;
                  end else begin
                     cmd.take       = 1'b1;
                     cmd.set_result = 1'b1;
                     state_in       = S_FINISH;
                  end
               end
               CMD_POP_AT: begin
                  cmd.set_result = 1'b1;
                  state_in       = S_FINISH;
                  if (flags.is_empty) begin
                     cmd.result_code = ST_NONE;
                  end else begin
                     cmd.take = 1'b1;
                  end
               end
               default: begin
                  cmd.set_result = 1'b1;
                  state_in       = S_FINISH;
               end
            endcase
         end
         S_FINISH: begin
            // Wait until the output register is free.
            if (!flags.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: hdl/bss_dp.sv
// Datapath of the stack set engine: request and scan registers, capacity
// register, fill count and word store memories, output register.
// Depends on bss_pkg and bss_ram.
`default_nettype none

module bss_dp import bss_pkg::*; #(
   parameter int STACK_COUNT  = 64,
   parameter int MAX_CAPACITY = 16,
   parameter int VALUE_WIDTH  = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_wr_en,
   input  wire logic [CAP_W-1:0]        csr_wr_data,
   input  wire logic [REQ_DATA_W-1:0]   req_tdata,
   input  wire logic [CODE_W-1:0]       req_tuser,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic      [RSP_DATA_W-1:0]   rsp_tdata,
   output logic      [CODE_W-1:0]       rsp_tuser,
   input  wire ctl_cmd_type             cmd,
   output dp_flags_type                 flags
);

   localparam int SIdxW    = $clog2(STACK_COUNT);
   localparam int CntW     = $clog2(MAX_CAPACITY + 1);
   localparam int SlotW    = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1;
   localparam int StoreD   = STACK_COUNT << SlotW;
   localparam int CapResV  = (CAP_RESET > MAX_CAPACITY) ? MAX_CAPACITY : CAP_RESET;
   localparam logic [CntW-1:0] CapReset = CntW'(CapResV);

   // Request and scan state.
   cmd_type                    cmd_ff;
   logic [VALUE_WIDTH-1:0]     val_ff;
   logic [STACK_INDEX_W-1:0]   idx_ff;
   logic [SIdxW-1:0]           ptr_ff, ptr_in;
   logic [SIdxW-1:0]           last_ff, last_in;
   logic [CntW-1:0]            cap_ff, cap_in;
   logic [STACK_COUNT-1:0]     valid_ff;
   logic                       vrd_ff;
   stat_type                   status_ff;
   logic                       use_store_ff;

   // Output register.
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]      rsp_data_ff, rsp_data_in;
   logic [CODE_W-1:0]          rsp_user_ff, rsp_user_in;

   // Memory interface.
   logic [CntW-1:0]            fill_q;
   logic [CntW-1:0]            cnt;
   logic [CntW-1:0]            slot;
   logic [SIdxW-1:0]           tgt;
   logic                       fill_wr_en;
   logic [SIdxW-1:0]           fill_wr_addr;
   logic [CntW-1:0]            fill_wr_data;
   logic [VALUE_WIDTH-1:0]     store_q;
   logic [WIDE_W-1:0]          wide_in, wide_out;
   logic [PUSH_VALUE_W-1:0]    push_value;
   logic [STACK_INDEX_W-1:0]   stack_index;
   cmd_type                    req_cmd;

   // Request fields: push_value in the low word, stack_index above it.
   assign push_value  = req_tdata[PUSH_VALUE_W-1:0];
   assign stack_index = req_tdata[PUSH_VALUE_W +: STACK_INDEX_W];
   assign req_cmd     = cmd_type'(req_tuser);
   assign wide_in     = WIDE_W'(push_value);

   // Fill count of the stack under the pointer; unwritten stacks read as zero.
   assign cnt  = vrd_ff ? fill_q : '0;
   assign tgt  = cmd.open_new ? (last_ff + SIdxW'(1)) : ptr_ff;
   assign slot = cmd.open_new ? '0 : cnt;

   // Capacity register write, clamped to the supported range.
   always_comb begin
      cap_in = cap_ff;
      if (csr_wr_en) begin
         priority if (csr_wr_data == '0) begin
            cap_in = CntW'(1);
         end else if (32'(csr_wr_data) > MAX_CAPACITY) begin
            cap_in = CntW'(MAX_CAPACITY);
         end else begin
            cap_in = CntW'(csr_wr_data);
         end
      end
   end

   // Scan pointer and rightmost stack in use.
   always_comb begin
      ptr_in  = ptr_ff;
      last_in = last_ff;
      if (cmd.accept) begin
         unique case (req_cmd)
            CMD_PUSH:   ptr_in = '0;
            CMD_POP:    ptr_in = last_ff;
            CMD_POP_AT: ptr_in = SIdxW'(stack_index);
            default:    ptr_in = '0;
         endcase
      end else if (cmd.step_up) begin
         ptr_in = ptr_ff + SIdxW'(1);
      end else if (cmd.step_down) begin
         ptr_in  = ptr_ff - SIdxW'(1);
         last_in = ptr_ff - SIdxW'(1);
      end
      if (cmd.open_new) begin
         last_in = last_ff + SIdxW'(1);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff      <= '0;
         cap_ff       <= CapReset;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         last_ff      <= last_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.write_push) begin
            valid_ff[tgt] <= 1'b1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      if (cmd.accept) begin
         cmd_ff <= req_cmd;
         val_ff <= wide_in[VALUE_WIDTH-1:0];
         idx_ff <= stack_index;
      end
      if (cmd.fetch) begin
         vrd_ff <= valid_ff[ptr_ff];
      end
      if (cmd.set_result) begin
         status_ff    <= cmd.result_code;
         use_store_ff <= cmd.take;
      end
   end

   // Fill count memory: a push stores count plus one, a pop count minus one.
   assign fill_wr_en   = cmd.write_push | cmd.take;
   assign fill_wr_addr = cmd.write_push ? tgt : ptr_ff;
   assign fill_wr_data = cmd.write_push ? (slot + CntW'(1)) : (cnt - CntW'(1));

   bss_ram #(
      .WIDTH (CntW),
      .DEPTH (STACK_COUNT)
   ) u_fill_ram (
      .clock   (clock),
      .wr_en   (fill_wr_en),
      .wr_addr (fill_wr_addr),
      .wr_data (fill_wr_data),
      .rd_en   (cmd.fetch),
      .rd_addr (ptr_ff),
      .rd_data (fill_q)
   );

   // Word store: one row of slots per stack.
   logic [CntW-1:0] top_slot;
   assign top_slot = cnt - CntW'(1);

   bss_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (StoreD)
   ) u_store_ram (
      .clock   (clock),
      .wr_en   (cmd.write_push),
      .wr_addr ({tgt, slot[SlotW-1:0]}),
      .wr_data (val_ff),
      .rd_en   (cmd.take),
      .rd_addr ({ptr_ff, top_slot[SlotW-1:0]}),
      .rd_data (store_q)
   );

   assign wide_out = WIDE_W'(store_q);

   // Output register: loaded when free or when the held transaction leaves.
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = use_store_ff ? wide_out[RSP_DATA_W-1:0] : '0;
         rsp_user_in  = status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Status toward the controller.
   always_comb begin
      flags.cmd       = cmd_ff;
      flags.index_bad = (32'(idx_ff) >= STACK_COUNT) || (32'(idx_ff) > 32'(last_ff));
      flags.has_room  = cnt < cap_ff;
      flags.is_empty  = cnt == '0;
      flags.at_last   = ptr_ff == last_ff;
      flags.at_zero   = ptr_ff == '0;
      flags.can_open  = last_ff != SIdxW'(STACK_COUNT - 1);
      flags.rsp_busy  = rsp_valid_ff & ~rsp_tready;
   end

endmodule

`default_nettype wire

FILE: hdl/bss_checker.sv
// Port-level checks of the stack set engine, bound to the top level.
// Depends on bss_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bss_checker import bss_pkg::*; (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_tvalid,
   input wire logic                    req_tready,
   input wire logic                    rsp_tvalid,
   input wire logic                    rsp_tready,
   input wire logic [RSP_DATA_W-1:0]   rsp_tdata,
   input wire logic [CODE_W-1:0]       rsp_tuser
);

   // A stalled result transaction keeps its payload.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

   // Results that are not done carry a zero value.
   `ASSERT_SAME(a_fail_zero, clock, reset, rsp_tvalid && (rsp_tuser != ST_DONE), rsp_tdata == '0, "failed result with nonzero value")

   // Only one request is in work: an accepted request drops ready.
   `ASSERT_NEXT(a_one_item, clock, reset, req_tvalid && req_tready, !req_tready, "request taken while one is in work")

   // A new result appears only while a request was in work.
   `ASSERT_SAME(a_rsp_source, clock, reset, $rose(rsp_tvalid), !$past(req_tready), "result without a request in work")

endmodule

bind bounded_stack_set_engine bss_checker u_bss_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
